/* rtl/core/ttf_pkg.sv */
// Shared types and constants for the table-driven state machine.
package ttf_pkg;

  // Default sizes handed to the top level
  localparam int DEF_TABLE_DEPTH   = 16;
  localparam int DEF_STATE_ID_BITS = 8;

  // Widest values the command word carries
  localparam int IDX_MAX_BITS   = 8;
  localparam int STATE_MAX_BITS = 16;
  localparam int EVENT_BITS     = 16;
  localparam int PORT_IDX_BITS  = 4;
  localparam int PORT_ST_BITS   = 8;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Action codes on the input channel
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_EVENT = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // Command kinds after classification
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_EVENT,
    CMD_RESET,
    CMD_NOP
  } cmd_kind_t;

  // One classified item as it travels through the queue
  typedef struct packed {
    cmd_kind_t                 kind;
    logic [IDX_MAX_BITS-1:0]   slot;
    logic                      ent_valid;
    logic [STATE_MAX_BITS-1:0] ent_source;
    logic [EVENT_BITS-1:0]     ent_evt;
    logic [STATE_MAX_BITS-1:0] ent_target;
    logic [EVENT_BITS-1:0]     evt_id;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } bk_state_t;

endpackage

/* rtl/core/transition_table_fsm.sv */
// Top level of the table-driven finite state machine.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | action, entry fields, event id
//   out_    | output    | out_valid/out_stall | current state, matched flag
//   cfg_    | input     | cfg_wr_en           | initial state (8 bits)
//
// Load, reset and unused items go straight to the finish state; an event item
// is scanned one entry per cycle, up to the first match or last entry, in the
// single-port table memory. Reset (rst_n, synchronous) empties the queue and
// marks every table entry invalid at once. The two-entry queue keeps taking
// items while the back end scans or while a result waits under out_stall.
module transition_table_fsm
  import ttf_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int STATE_ID_BITS = DEF_STATE_ID_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [PORT_ST_BITS-1:0]  cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [PORT_IDX_BITS-1:0] in_entry_index,
  input  logic                     in_entry_valid,
  input  logic [PORT_ST_BITS-1:0]  in_entry_source,
  input  logic signed [EVENT_BITS-1:0] in_entry_event,
  input  logic [PORT_ST_BITS-1:0]  in_entry_target,
  input  logic signed [EVENT_BITS-1:0] in_event_id,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PORT_ST_BITS-1:0]  out_current_state,
  output logic                     out_matched
);

  cmd_t front_cmd;
  cmd_t q_data;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify items
  ttf_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_entry_valid (in_entry_valid),
    .in_entry_source(in_entry_source),
    .in_entry_event (in_entry_event),
    .in_entry_target(in_entry_target),
    .in_event_id    (in_event_id),
    .cmd            (front_cmd)
  );

  // command queue
  ttf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_data)
  );

  // table, state and result
  ttf_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .STATE_ID_BITS(STATE_ID_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_not_empty      (q_not_empty),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_current_state(out_current_state),
    .out_matched      (out_matched)
  );

endmodule

/* rtl/core/ttf_front.sv */
// Front end: classifies incoming items into commands for the queue.
module ttf_front
  import ttf_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic [1:0]               in_action,
  input  logic [PORT_IDX_BITS-1:0] in_entry_index,
  input  logic                     in_entry_valid,
  input  logic [PORT_ST_BITS-1:0]  in_entry_source,
  input  logic [EVENT_BITS-1:0]    in_entry_event,
  input  logic [PORT_ST_BITS-1:0]  in_entry_target,
  input  logic [EVENT_BITS-1:0]    in_event_id,
  output cmd_t                     cmd
);

  logic in_range;

  // slots past the end of the table are dropped
  assign in_range = (32'(in_entry_index) < TABLE_DEPTH);

  // build the command word
  always_comb begin
    cmd.slot       = IDX_MAX_BITS'(in_entry_index);
    cmd.ent_valid  = in_entry_valid;
    cmd.ent_source = STATE_MAX_BITS'(in_entry_source);
    cmd.ent_evt    = in_entry_event;
    cmd.ent_target = STATE_MAX_BITS'(in_entry_target);
    cmd.evt_id     = in_event_id;
    unique case (in_action)
      ACT_LOAD:  cmd.kind = in_range ? CMD_LOAD : CMD_NOP;
      ACT_EVENT: cmd.kind = CMD_EVENT;
      ACT_RESET: cmd.kind = CMD_RESET;
      ACT_NOP:   cmd.kind = CMD_NOP;
    endcase
  end

endmodule

/* rtl/core/ttf_queue.sv */
// Short command queue decoupling the front end from the back end.
module ttf_queue
  import ttf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_data
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t           slots_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW:0]   count_r;

  assign full      = (count_r == (QPW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/ttf_back.sv */
// Back end: holds the transition table, runs loads, resets and event scans.
module ttf_back
  import ttf_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int STATE_ID_BITS = DEF_STATE_ID_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [PORT_ST_BITS-1:0] cfg_wr_data,
  input  logic                    q_not_empty,
  input  cmd_t                    q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PORT_ST_BITS-1:0] out_current_state,
  output logic                    out_matched
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = IW + 1;
  localparam int SB = STATE_ID_BITS;
  localparam int MW = 2*SB + EVENT_BITS;

  // table memory: source, event, target; valid bits kept in flops
  logic [MW-1:0]          mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  bk_state_t              state_r, state_nxt;
  logic [SB-1:0]          cur_state_r;
  logic                   state_set_r;
  logic                   matched_r;
  logic [EVENT_BITS-1:0]  ev_r;
  logic [CW-1:0]          issue_r;
  logic                   rd_pend_r;
  logic [IW-1:0]          rd_idx_r;
  logic [MW-1:0]          rd_word_r;
  logic [PORT_ST_BITS-1:0] init_r;
  logic                   out_valid_r;
  logic [PORT_ST_BITS-1:0] out_state_r;
  logic                   out_matched_r;

  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic                   hit;
  logic                   last;
  logic                   out_free;
  logic                   finish_wr;
  logic [SB-1:0]          rd_src;
  logic [EVENT_BITS-1:0]  rd_evt;
  logic [SB-1:0]          rd_tgt;
  logic [SB-1:0]          init_state;
  logic [STATE_MAX_BITS-1:0] init_wide;
  logic [STATE_MAX_BITS-1:0] cur_wide;
  logic [IW-1:0]          load_slot;

  // width adjustments between port widths and state id width
  assign init_wide  = STATE_MAX_BITS'(init_r);
  assign init_state = init_wide[SB-1:0];
  assign cur_wide   = STATE_MAX_BITS'(cur_state_r);
  assign load_slot  = q_data.slot[IW-1:0];
  assign rd_addr    = issue_r[IW-1:0];

  assign {rd_src, rd_evt, rd_tgt} = rd_word_r;

  // scan compare on the registered read
  assign hit  = rd_pend_r && valid_r[rd_idx_r] && (rd_src == cur_state_r) && (rd_evt == ev_r);
  assign last = rd_pend_r && (rd_idx_r == IW'(TABLE_DEPTH-1));
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = (q_data.kind == CMD_EVENT) ? BK_SCAN : BK_FINISH;
        end
      end
      BK_SCAN: begin
        if (hit || last) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    finish_wr = 1'b0;
    unique case (state_r)
      BK_IDLE:   q_pop     = q_not_empty;
      BK_SCAN:   rd_en     = (issue_r < CW'(TABLE_DEPTH));
      BK_FINISH: finish_wr = out_free;
      default: ;
    endcase
  end

  // table memory write and registered read
  always_ff @(posedge clk) begin
    if (q_pop && (q_data.kind == CMD_LOAD)) begin
      mem[load_slot] <= {q_data.ent_source[SB-1:0], q_data.ent_evt,
                         q_data.ent_target[SB-1:0]};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r <= q_data.evt_id;
    end
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    if (finish_wr) begin
      out_state_r   <= cur_wide[PORT_ST_BITS-1:0];
      out_matched_r <= matched_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      cur_state_r <= '0;
      state_set_r <= 1'b0;
      matched_r   <= 1'b0;
      issue_r     <= '0;
      rd_pend_r   <= 1'b0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        init_r <= cfg_wr_data;
      end
      // start of a command
      if (q_pop) begin
        matched_r <= 1'b0;
        issue_r   <= '0;
        rd_pend_r <= 1'b0;
        unique case (q_data.kind)
          CMD_LOAD: valid_r[load_slot] <= q_data.ent_valid;
          CMD_EVENT: begin
            if (!state_set_r) begin
              cur_state_r <= init_state;
              state_set_r <= 1'b1;
            end
          end
          CMD_RESET: begin
            cur_state_r <= init_state;
            state_set_r <= 1'b1;
          end
          CMD_NOP: ;
        endcase
      end
      // scan: one read issued and one entry checked per cycle
      if (state_r == BK_SCAN) begin
        rd_pend_r <= rd_en;
        if (rd_en) begin
          issue_r <= issue_r + 1'b1;
        end
        if (hit) begin
          cur_state_r <= rd_tgt;
          matched_r   <= 1'b1;
        end
      end
      // output register
      if (finish_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_state = out_state_r;
  assign out_matched       = out_matched_r;

endmodule
